@@ rtl/core/dcfp_pkg.sv @@
`timescale 1ns / 1ps

package dcfp_pkg;

    localparam logic [7:0] OPEN_MARK  = 8'h3C;
    localparam logic [7:0] CLOSE_MARK = 8'h3E;

    localparam logic FUNC_BYTE    = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_CODE   = 3'd1,
        PH_SIZE_L = 3'd2,
        PH_SIZE_H = 3'd3,
        PH_DATA   = 3'd4,
        PH_CLOSE  = 3'd5,
        PH_DONE   = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        KIND_OTHER   = 2'd0,
        KIND_OPEN    = 2'd1,
        KIND_CLOSE   = 2'd2,
        KIND_RELEASE = 2'd3
    } item_kind_t;

    typedef struct packed {
        item_kind_t kind;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic        accepted;
        logic        payload_valid;
        logic [7:0]  payload_data;
        logic [15:0] payload_index;
        logic        frame_done;
        logic [7:0]  command_code;
        logic [15:0] command_length;
    } result_t;

endpackage

@@ rtl/core/dcfp_if.sv @@
`timescale 1ns / 1ps

interface dcfp_item_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] rx_byte;

    modport source (output valid, func, rx_byte, input ready);
    modport sink (input valid, func, rx_byte, output ready);
endinterface

interface dcfp_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  phase;
    logic        accepted;
    logic        payload_valid;
    logic [7:0]  payload_data;
    logic [15:0] payload_index;
    logic        frame_done;
    logic [7:0]  command_code;
    logic [15:0] command_length;

    modport source (output valid, phase, accepted, payload_valid, payload_data,
                    payload_index, frame_done, command_code, command_length,
                    input ready);
    modport sink (input valid, phase, accepted, payload_valid, payload_data,
                  payload_index, frame_done, command_code, command_length,
                  output ready);
endinterface

@@ rtl/core/dcfp_front.sv @@
`timescale 1ns / 1ps

module dcfp_front (
    dcfp_item_if.sink     rx,
    input  logic          push_ready,
    output logic          push_valid,
    output dcfp_pkg::item_t push_item
);
    import dcfp_pkg::*;

    assign rx.ready   = push_ready;
    assign push_valid = rx.valid;

    // tag each transaction so the back end only checks a small kind code
    always_comb
    begin
        push_item.data = rx.rx_byte;
        if (rx.func == FUNC_RELEASE)
        begin
            push_item.kind = KIND_RELEASE;
        end
        else if (rx.rx_byte == OPEN_MARK)
        begin
            push_item.kind = KIND_OPEN;
        end
        else if (rx.rx_byte == CLOSE_MARK)
        begin
            push_item.kind = KIND_CLOSE;
        end
        else
        begin
            push_item.kind = KIND_OTHER;
        end
    end

endmodule

@@ rtl/core/dcfp_queue.sv @@
`timescale 1ns / 1ps

module dcfp_queue #(
    parameter int DEPTH = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push_valid,
    input  dcfp_pkg::item_t            push_item,
    output logic                       push_ready,
    output logic                       pop_valid,
    output dcfp_pkg::item_t            pop_item,
    input  logic                       pop_ready,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    import dcfp_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    item_t            entry_reg [DEPTH];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CntW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign count      = count_reg;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/core/dcfp_back.sv @@
`timescale 1ns / 1ps

module dcfp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    input  dcfp_pkg::item_t   pop_item,
    output logic              pop_ready,
    dcfp_result_if.source     res
);
    import dcfp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  code_reg, code_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] taken_reg, taken_next;
    logic [15:0] size_full;
    logic [15:0] taken_inc;
    logic        step;

    result_t     result_reg, result_next;
    logic        res_valid_reg;

    // output register frees up when empty or being drained this cycle
    assign pop_ready = !res_valid_reg || res.ready;
    assign step      = pop_valid && pop_ready;
    assign size_full = {pop_item.data, length_reg[7:0]};
    assign taken_inc = taken_reg + 16'd1;

    // next state
    always_comb
    begin
        phase_next  = phase_reg;
        code_next   = code_reg;
        length_next = length_reg;
        taken_next  = taken_reg;
        if (pop_item.kind == KIND_RELEASE)
        begin
            phase_next = PH_HUNT;
            taken_next = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_CODE:
                begin
                    code_next  = pop_item.data;
                    phase_next = PH_SIZE_L;
                end
                PH_SIZE_L:
                begin
                    length_next = {8'd0, pop_item.data};
                    phase_next  = PH_SIZE_H;
                end
                PH_SIZE_H:
                begin
                    length_next = size_full;
                    taken_next  = '0;
                    phase_next  = (size_full == 16'd0) ? PH_CLOSE : PH_DATA;
                end
                PH_DATA:
                begin
                    taken_next = taken_inc;
                    if (taken_inc == length_reg)
                    begin
                        phase_next = PH_CLOSE;
                    end
                end
                PH_CLOSE:
                begin
                    if (pop_item.kind == KIND_CLOSE)
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_DONE:
                begin
                    phase_next = PH_DONE;
                end
                default:
                begin
                    // hunt, and the unused code that behaves as hunt
                    if (pop_item.kind == KIND_OPEN)
                    begin
                        code_next   = '0;
                        length_next = '0;
                        taken_next  = '0;
                        phase_next  = PH_CODE;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
            endcase
        end
    end

    // outputs
    always_comb
    begin
        result_next                = '0;
        result_next.phase          = phase_next;
        result_next.command_code   = code_next;
        result_next.command_length = length_next;
        if (pop_item.kind != KIND_RELEASE)
        begin
            unique case (phase_reg)
                PH_DATA:
                begin
                    result_next.accepted      = 1'b1;
                    result_next.payload_valid = 1'b1;
                    result_next.payload_data  = pop_item.data;
                    result_next.payload_index = taken_reg;
                end
                PH_CLOSE:
                begin
                    result_next.accepted   = 1'b1;
                    result_next.frame_done = (pop_item.kind == KIND_CLOSE);
                end
                PH_DONE:
                begin
                    result_next.accepted = 1'b0;
                end
                default:
                begin
                    result_next.accepted = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            code_reg      <= '0;
            length_reg    <= '0;
            taken_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                phase_reg  <= phase_next;
                code_reg   <= code_next;
                length_reg <= length_next;
                taken_reg  <= taken_next;
            end
            if (pop_ready)
            begin
                res_valid_reg <= pop_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= result_next;
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.phase          = result_reg.phase;
    assign res.accepted       = result_reg.accepted;
    assign res.payload_valid  = result_reg.payload_valid;
    assign res.payload_data   = result_reg.payload_data;
    assign res.payload_index  = result_reg.payload_index;
    assign res.frame_done     = result_reg.frame_done;
    assign res.command_code   = result_reg.command_code;
    assign res.command_length = result_reg.command_length;

endmodule

@@ rtl/core/delimited_command_frame_parser_unit.sv @@
`timescale 1ns / 1ps

// Streaming parser for frames of the form '<' code size_lo size_hi payload '>'.
// Each input transaction (a byte, or a release) yields exactly one result
// transaction carrying the phase after that byte, the payload byte and its
// index when it is one, and the frame's command code and length. One
// transaction is taken per cycle while the queue has room; a byte goes
// through the classifier into a QUEUE_DEPTH-entry queue, and the parse
// state machine registers its result in the output register as the byte
// leaves the queue. The back end updates its state once per transaction,
// so that state machine sets the sustained rate of one transaction per
// clock while the result side keeps taking. Once a frame is complete,
// bytes are answered with accepted = 0 until a release arrives.

module delimited_command_frame_parser_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    dcfp_item_if.sink     rx,
    dcfp_result_if.source res
);
    import dcfp_pkg::*;

    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    logic            push_valid, push_ready;
    item_t           push_item;
    logic            pop_valid, pop_ready;
    item_t           pop_item;
    logic [CntW-1:0] queue_count;

    dcfp_front u_front (
        .rx         (rx),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_item  (push_item)
    );

    dcfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready),
        .count      (queue_count)
    );

    dcfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_item  (pop_item),
        .pop_ready (pop_ready),
        .res       (res)
    );

    a_queue_bound : assert property (@(posedge clk) disable iff (!rst_n)
        queue_count <= CntW'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    a_payload_accepted : assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.payload_valid |->
            res.accepted && (res.phase == PH_DATA || res.phase == PH_CLOSE))
        else $error("payload byte without acceptance or in wrong phase");

    a_done_phase : assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.frame_done |-> res.accepted && res.phase == PH_DONE)
        else $error("frame done reported outside complete phase");

    a_refused_done : assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.accepted && !res.frame_done |->
            !res.payload_valid && (res.phase == PH_DONE || res.phase == PH_HUNT))
        else $error("refused transaction left an unexpected phase");

endmodule
